### hdl/assert_macros.svh
// Assertion macros shared by the skipper RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define LCWS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent (use |-> or |=> inside prop)
`define LCWS_ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### hdl/lcws_pkg.sv
// Types and constants of the comment and whitespace skipper
package lcws_pkg;

  // skip mode codes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_HASH   = 3'd1;
  localparam logic [2:0] MODE_LINE   = 3'd2;
  localparam logic [2:0] MODE_BLOCK  = 3'd3;
  localparam logic [2:0] MODE_BHASH  = 3'd4;
  localparam logic [2:0] MODE_BBAR   = 3'd5;

  // result status codes
  localparam logic [1:0] ST_CHAR = 2'd0;
  localparam logic [1:0] ST_EOF  = 2'd1;
  localparam logic [1:0] ST_OPEN = 2'd2;
  localparam logic [1:0] ST_OVER = 2'd3;

  // characters of interest
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // result queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  // one result word
  typedef struct packed {
    logic [7:0] chr;
    logic [1:0] status;
    logic       last;
  } res_t;

  // results of one input word: count and up to two words
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_out_t;

endpackage

### hdl/lcws_step.sv
// Per-byte mode and nesting update with result generation
module lcws_step #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic [2:0]            mode,
  input  logic [DEPTH_BITS-1:0] depth,
  input  logic [7:0]            chr,
  input  logic                  eoi,
  input  logic                  ats,
  output logic [2:0]            mode_nxt,
  output logic [DEPTH_BITS-1:0] depth_nxt,
  output lcws_pkg::step_out_t   res
);
  import lcws_pkg::*;

  logic                  blank;
  logic [2:0]            blk_mode;
  logic [DEPTH_BITS-1:0] depth_dec;

  // whitespace: tab..cr and space
  assign blank = (chr == CH_SPACE) || ((chr >= CH_TAB) && (chr <= CH_CR));

  // fresh look at a byte inside a block comment
  assign blk_mode = (chr == CH_HASH) ? MODE_BHASH :
                    (chr == CH_BAR)  ? MODE_BBAR  : MODE_BLOCK;

  assign depth_dec = (depth != '0) ? depth - 1'b1 : depth;

  always_comb begin
    mode_nxt  = mode;
    depth_nxt = depth;
    res       = '0;
    if (eoi) begin
      res.n         = 2'd1;
      res.r0.status = (mode >= MODE_BLOCK && mode <= MODE_BBAR) ? ST_OPEN : ST_EOF;
      res.r0.last   = 1'b1;
      mode_nxt      = MODE_NORMAL;
      depth_nxt     = '0;
    end else begin
      unique case (mode)
        MODE_HASH: begin
          if (chr == CH_T || chr == CH_F) begin
            mode_nxt  = MODE_NORMAL;
            res.n     = 2'd2;
            res.r0.chr = CH_HASH;
            res.r1.chr = chr;
            res.r1.last = 1'b1;
          end else if (chr == CH_BAR) begin
            depth_nxt = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
            mode_nxt  = MODE_BLOCK;
          end else if (chr == CH_NL) begin
            mode_nxt = MODE_NORMAL;
          end else begin
            mode_nxt = MODE_LINE;
          end
        end
        MODE_LINE: begin
          if (chr == CH_NL) mode_nxt = MODE_NORMAL;
        end
        MODE_BLOCK: begin
          mode_nxt = blk_mode;
        end
        MODE_BHASH: begin
          if (chr == CH_BAR) begin
            mode_nxt = MODE_BLOCK;
            if (&depth) begin
              // depth saturates, comment goes on
              res.n         = 2'd1;
              res.r0.status = ST_OVER;
              res.r0.last   = 1'b1;
            end else begin
              depth_nxt = depth + 1'b1;
            end
          end else begin
            mode_nxt = blk_mode;
          end
        end
        MODE_BBAR: begin
          if (chr == CH_HASH) begin
            depth_nxt = depth_dec;
            mode_nxt  = (depth_dec == '0) ? MODE_NORMAL : MODE_BLOCK;
          end else begin
            mode_nxt = blk_mode;
          end
        end
        default: begin
          // normal scanning; unused codes behave the same
          mode_nxt = MODE_NORMAL;
          if (!ats || (chr != CH_SEMI && chr != CH_HASH && !blank)) begin
            res.n       = 2'd1;
            res.r0.chr  = chr;
            res.r0.last = 1'b1;
          end else if (chr == CH_SEMI) begin
            mode_nxt = MODE_LINE;
          end else if (chr == CH_HASH) begin
            mode_nxt = MODE_HASH;
          end
        end
      endcase
    end
  end

endmodule

### hdl/lcws_outq.sv
// Small result queue taking up to two words a cycle, giving one
`include "assert_macros.svh"
module lcws_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  lcws_pkg::step_out_t push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output lcws_pkg::res_t      out_res
);
  import lcws_pkg::*;

  res_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           pop;
  logic [QAW-1:0] wr_ptr_p1;

  // room for a full two-word push
  assign room      = (cnt_r <= QAW'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  assign wr_ptr_nxt = wr_ptr_r + push.n[QAW-1:0];
  assign rd_ptr_nxt = rd_ptr_r + {{(QAW-1){1'b0}}, pop};
  assign cnt_nxt    = cnt_r + {1'b0, push.n} - {{QAW{1'b0}}, pop};

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.n == 2'd2) mem_r[wr_ptr_p1] <= push.r1;
  end

  `LCWS_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= (QAW+1)'(QDEPTH),
                      "result queue count beyond depth")
  `LCWS_ASSERT_PROP(a_push_room, clk, rst_n, (push.n != 2'd0) |-> room,
                    "push into a queue without room")
  `LCWS_ASSERT_PROP(a_cnt_track, clk, rst_n,
                    1'b1 |=> (cnt_r == ($past(cnt_r) + {1'b0, $past(push.n)}
                                       - {{QAW{1'b0}}, $past(pop)})),
                    "queue count does not follow pushes and pops")

endmodule

### hdl/lisp_comment_whitespace_skipper.sv
// Lisp reader front end: skips whitespace and comments at token boundaries
// An accepted word waits in the input register; its results are then written to the result queue.
// Throughput: one input word per cycle while the result side drains; "#t"/"#f"
//   give two result words, so sustained output is one result word per cycle.
// Intake stalls only when the four-word result queue cannot take two more words.
// Reset (rst_n low, synchronous): normal scanning, nesting depth zero, queue empty.
`include "assert_macros.svh"
module lisp_comment_whitespace_skipper #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  input  logic       in_at_token_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_last
);
  import lcws_pkg::*;

  logic                  stg_v_r, stg_v_nxt;
  logic [7:0]            stg_byte_r;
  logic                  stg_eoi_r;
  logic                  stg_ats_r;
  logic [2:0]            mode_r, mode_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  step_out_t             step_res;
  step_out_t             push;
  logic                  room;
  logic                  fire;
  logic                  in_fire;
  res_t                  q_res;

  // stage word is processed when the queue can take its results
  assign fire     = stg_v_r && room;
  assign in_ready = !stg_v_r || fire;
  assign in_fire  = in_valid && in_ready;
  assign stg_v_nxt = in_fire ? 1'b1 : (fire ? 1'b0 : stg_v_r);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_byte_r <= in_byte;
      stg_eoi_r  <= in_end_of_input;
      stg_ats_r  <= in_at_token_start;
    end
  end

  lcws_step #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_step (
    .mode      (mode_r),
    .depth     (depth_r),
    .chr       (stg_byte_r),
    .eoi       (stg_eoi_r),
    .ats       (stg_ats_r),
    .mode_nxt  (mode_nxt),
    .depth_nxt (depth_nxt),
    .res       (step_res)
  );

  // scanner state advances once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      depth_r <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
    end
  end

  assign push = fire ? step_res : '0;

  lcws_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (q_res)
  );

  assign out_byte   = q_res.chr;
  assign out_status = q_res.status;
  assign out_last   = q_res.last;

  `LCWS_ASSERT_PROP(a_stage_hold, clk, rst_n, (stg_v_r && !fire) |=> stg_v_r,
                    "stalled stage word lost")
  `LCWS_ASSERT_PROP(a_eoi_clears, clk, rst_n, (fire && stg_eoi_r) |=>
                    (mode_r == MODE_NORMAL && depth_r == '0),
                    "end of input does not clear scanner state")
  `LCWS_ASSERT_PROP(a_status_byte, clk, rst_n,
                    (out_valid && out_status != ST_CHAR) |-> (out_byte == 8'd0 && out_last),
                    "status result carries a byte or is not last")

endmodule

### test/tb_lisp_comment_whitespace_skipper.sv
// Testbench for the Lisp reader comment and whitespace skipper
`timescale 1ns / 1ps

import lcws_pkg::*;

// whitespace as the reader sees it: tab to carriage return, and space
function automatic bit is_blank_byte(logic [7:0] b);
  return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
endfunction

// Tracks the skip mode and nesting depth, and holds the result words still due
class skip_board #(int unsigned DW = 8);
  logic [2:0]    mode;
  logic [DW-1:0] depth;
  res_t          due_results[$];
  int unsigned   mismatches;
  int unsigned   results_seen;

  function new();
    mode         = MODE_NORMAL;
    depth        = '0;
    mismatches   = 0;
    results_seen = 0;
  endfunction

  // mode inside a block comment after an ordinary or delimiter byte
  function logic [2:0] block_after(logic [7:0] b);
    if (b == CH_HASH) return MODE_BHASH;
    if (b == CH_BAR) return MODE_BBAR;
    return MODE_BLOCK;
  endfunction

  function void owe(logic [7:0] c, logic [1:0] st, logic l);
    res_t r;
    r.chr    = c;
    r.status = st;
    r.last   = l;
    due_results.push_back(r);
  endfunction

  // note an accepted input word and work out the words it causes
  function void take_word(logic [7:0] b, logic eoi, logic ats);
    if (mode > MODE_BBAR) mode = MODE_NORMAL;
    if (eoi) begin
      owe(8'h00, (mode >= MODE_BLOCK) ? ST_OPEN : ST_EOF, 1'b1);
      mode  = MODE_NORMAL;
      depth = '0;
      return;
    end
    case (mode)
      MODE_NORMAL: begin
        if (!ats || (b != CH_SEMI && b != CH_HASH && !is_blank_byte(b))) owe(b, ST_CHAR, 1'b1);
        else if (b == CH_SEMI) mode = MODE_LINE;
        else if (b == CH_HASH) mode = MODE_HASH;
      end
      MODE_HASH: begin
        if (b == CH_T || b == CH_F) begin
          mode = MODE_NORMAL;
          owe(CH_HASH, ST_CHAR, 1'b0);
          owe(b, ST_CHAR, 1'b1);
        end else if (b == CH_BAR) begin
          depth = DW'(1);
          mode  = MODE_BLOCK;
        end else if (b == CH_NL) begin
          mode = MODE_NORMAL;
        end else begin
          mode = MODE_LINE;
        end
      end
      MODE_LINE: begin
        if (b == CH_NL) mode = MODE_NORMAL;
      end
      MODE_BLOCK: mode = block_after(b);
      MODE_BHASH: begin
        if (b == CH_BAR) begin
          mode = MODE_BLOCK;
          // depth saturates, the comment carries on
          if (&depth) owe(8'h00, ST_OVER, 1'b1);
          else depth = depth + 1'b1;
        end else begin
          mode = block_after(b);
        end
      end
      default: begin
        if (b == CH_HASH) begin
          if (depth != 0) depth = depth - 1'b1;
          mode = (depth == 0) ? MODE_NORMAL : MODE_BLOCK;
        end else begin
          mode = block_after(b);
        end
      end
    endcase
  endfunction

  // compare one accepted result word with the oldest one due
  function void match_result(logic [7:0] c, logic [1:0] st, logic l);
    res_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected word chr=%h status=%0d last=%b", $time, c, st, l);
      return;
    end
    want = due_results.pop_front();
    if (want.chr !== c) begin
      mismatches++;
      $display("%0t: out_byte expected %h actual %h", $time, want.chr, c);
    end
    if (want.status !== st) begin
      mismatches++;
      $display("%0t: out_status expected %0d actual %0d", $time, want.status, st);
    end
    if (want.last !== l) begin
      mismatches++;
      $display("%0t: out_last expected %b actual %b", $time, want.last, l);
    end
  endfunction
endclass

module tb_lisp_comment_whitespace_skipper;
  localparam int unsigned DEPTH_W    = 8;
  localparam int unsigned RAND_WORDS = 440;
  localparam int unsigned IDLE_LIMIT = 2000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_end_of_input;
  logic       in_at_token_start;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_last;

  skip_board #(DEPTH_W) board;
  int unsigned n_words;
  int unsigned quiet_cycles;
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  bit          calm;

  lisp_comment_whitespace_skipper #(.DEPTH_BITS(DEPTH_W)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_end_of_input   (in_end_of_input),
    .in_at_token_start (in_at_token_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit rbit();
    return bit'($urandom_range(0, 1));
  endfunction

  function automatic int unsigned gap_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 6;
      default: return 25;
    endcase
  endfunction

  function automatic logic [7:0] rand_except(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [7:0] v;
    do v = 8'($urandom); while (v == a || v == b || v == c);
    return v;
  endfunction

  // offer one word at a falling edge and hold it until taken
  task automatic send_word(logic [7:0] b, logic eoi, logic ats);
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_byte           <= b;
    in_end_of_input   <= eoi;
    in_at_token_start <= ats;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_words++;
  endtask

  task automatic send_text(string s, logic ats);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0, ats);
  endtask

  // well-formed block comment with random filler, nested up to four deep
  task automatic send_block(int unsigned lvl);
    int unsigned n;
    if (lvl > 1 && $urandom_range(0, 3) == 0) send_word(CH_HASH, 1'b0, rbit());
    send_word(CH_HASH, 1'b0, (lvl == 1) ? 1'b1 : rbit());
    send_word(CH_BAR, 1'b0, rbit());
    n = $urandom_range(0, 6);
    repeat (n) begin
      if (lvl < 4 && $urandom_range(0, 4) == 0) send_block(lvl + 1);
      else send_word(rand_except(CH_HASH, CH_BAR, CH_BAR), 1'b0, rbit());
    end
    if ($urandom_range(0, 3) == 0) send_word(CH_BAR, 1'b0, rbit());
    send_word(CH_BAR, 1'b0, rbit());
    send_word(CH_HASH, 1'b0, rbit());
  endtask

  // result side: random stall bursts, none once calm
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < out_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.match_result(out_byte, out_status, out_last);
      if (in_valid && in_ready) board.take_word(in_byte, in_end_of_input, in_at_token_start);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("** lisp_comment_whitespace_skipper: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  b;
    int unsigned base;
    int unsigned n;

    board             = new();
    n_words           = 0;
    quiet_cycles      = 0;
    calm              = 1'b0;
    in_gap_pct        = 6;
    out_stall_pct     = 6;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_byte           = 8'h00;
    in_end_of_input   = 1'b0;
    in_at_token_start = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: blanks and their neighbours, byte extremes
    send_text(" \t", 1'b1);
    send_word(CH_CR, 1'b0, 1'b1);
    send_word(8'd8, 1'b0, 1'b1);
    send_word(8'd14, 1'b0, 1'b1);
    send_word(8'hFF, 1'b0, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);
    // line comment, skipped even between tokens; pass-through of specials
    send_text(";x", 1'b1);
    send_text("y\n", 1'b0);
    send_text(" ;#", 1'b0);
    // hash letters, hash-newline, hash line comment
    send_text("#t#f#\n#a\n", 1'b1);
    // nested block with "##|" and "||#"
    send_text("#|a##||#|#", 1'b1);
    // end of input after a lone hash, inside a block, and between tokens
    send_word(CH_HASH, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1);
    send_text("#|", 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h41, 1'b1, 1'b0);

    // depth saturation: three openers past the top
    send_word(CH_HASH, 1'b0, 1'b1);
    send_word(CH_BAR, 1'b0, rbit());
    repeat ((1 << DEPTH_W) + 1) begin
      send_word(CH_HASH, 1'b0, rbit());
      send_word(CH_BAR, 1'b0, rbit());
    end
    send_text("|#", 1'b0);
    send_word(8'h00, 1'b1, 1'b1);

    // random sequences, mostly well formed
    base = n_words;
    while (n_words - base < RAND_WORDS) begin
      if (n_words - base >= RAND_WORDS - 120) calm = 1'b1;
      if ($urandom_range(0, 15) == 0) begin
        in_gap_pct    = gap_pct();
        out_stall_pct = gap_pct();
      end
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          // token: significant byte, then pass-through bytes
          do b = 8'($urandom); while (is_blank_byte(b) || b == CH_SEMI || b == CH_HASH);
          send_word(b, 1'b0, 1'b1);
          n = $urandom_range(0, 5);
          repeat (n) send_word(8'($urandom), 1'b0, 1'b0);
        end
        3: begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            b = 8'($urandom_range(9, 14));
            if (b == 8'd14) b = CH_SPACE;
            send_word(b, 1'b0, 1'b1);
          end
        end
        4: begin
          send_word(CH_SEMI, 1'b0, 1'b1);
          n = $urandom_range(0, 6);
          repeat (n) send_word(rand_except(CH_NL, CH_NL, CH_NL), 1'b0, rbit());
          send_word(CH_NL, 1'b0, rbit());
        end
        5: begin
          send_word(CH_HASH, 1'b0, 1'b1);
          if (rbit()) begin
            send_word(rand_except(CH_BAR, CH_T, CH_F), 1'b0, rbit());
            n = $urandom_range(0, 4);
            repeat (n) send_word(rand_except(CH_NL, CH_NL, CH_NL), 1'b0, rbit());
          end
          send_word(CH_NL, 1'b0, rbit());
        end
        6, 7: send_block(1);
        8: begin
          send_word(CH_HASH, 1'b0, 1'b1);
          send_word(rbit() ? CH_T : CH_F, 1'b0, rbit());
        end
        9: begin
          // block left open at end of input
          send_text("#|", 1'b1);
          n = $urandom_range(0, 3);
          repeat (n) send_word(rand_except(CH_HASH, CH_BAR, CH_BAR), 1'b0, rbit());
          send_word(8'($urandom), 1'b1, rbit());
        end
        10: begin
          n = $urandom_range(1, 4);
          repeat (n) send_word(8'($urandom), ($urandom_range(0, 7) == 0), rbit());
        end
        default: send_word(8'($urandom), 1'b1, rbit());
      endcase
    end

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("** lisp_comment_whitespace_skipper: PASSED **");
    end else begin
      $display("** lisp_comment_whitespace_skipper: FAILED **");
    end
    $finish;
  end

endmodule
